@@ rtl/core/vds_pkg.sv @@
package vds_pkg;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned BLOCKS_W    = 8;
  localparam int unsigned BYTES_W     = 12;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned BLOCK_BYTES = 16;

  localparam logic [BYTES_W-1:0]  BYTES_MAX = {BYTES_W{1'b1}};
  localparam logic [BYTES_W-1:0]  ARM_BYTES = (BLOCK_BYTES > BYTES_MAX) ?
                                              BYTES_MAX : BYTES_W'(BLOCK_BYTES);
  localparam logic [ADDR_W-1:0]   ADDR_STEP = ADDR_W'(2);
  localparam logic [BYTES_W-1:0]  BYTE_STEP = BYTES_W'(2);

  typedef enum logic {
    OpTick  = 1'b0,
    OpStart = 1'b1
  } op_e;

  // One input transaction.
  typedef struct packed {
    op_e                 opcode;
    logic                cpu_idle;
    logic                in_hblank;
    logic [ADDR_W-1:0]   start_source;
    logic [ADDR_W-1:0]   start_dest;
    logic                start_hblank_mode;
    logic [BLOCKS_W-1:0] start_blocks;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic              copy_valid;
    logic [ADDR_W-1:0] copy_source;
    logic [ADDR_W-1:0] copy_dest;
    logic              cpu_clock_enable;
    logic              busy;
    logic              finished;
  } res_t;

endpackage

@@ rtl/core/vds_seq.sv @@
module vds_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  vds_pkg::item_t item_i,
  output vds_pkg::res_t  res_o
);
  import vds_pkg::*;

  logic                gen_q, gen_d;
  logic                hb_q, hb_d;
  logic [ADDR_W-1:0]   src_q, src_d;
  logic [ADDR_W-1:0]   dst_q, dst_d;
  logic [BYTES_W-1:0]  bytes_q, bytes_d;
  logic [BLOCKS_W-1:0] blocks_q, blocks_d;
  logic                hold_q, hold_d;
  logic                was_hb_q, was_hb_d;

  logic [LEN_W-1:0]    len;
  logic                do_copy;
  logic [BYTES_W-1:0]  bytes_nxt;
  logic [BLOCKS_W-1:0] blocks_nxt;

  assign len        = LEN_W'(item_i.start_blocks) * LEN_W'(BLOCK_BYTES);
  assign do_copy    = item_i.cpu_idle && (gen_q || (hb_q && (bytes_q != '0)));
  assign bytes_nxt  = (bytes_q > BYTE_STEP) ? (bytes_q - BYTE_STEP) : '0;
  assign blocks_nxt = blocks_q - BLOCKS_W'(1);

  always_comb begin
    gen_d    = gen_q;
    hb_d     = hb_q;
    src_d    = src_q;
    dst_d    = dst_q;
    bytes_d  = bytes_q;
    blocks_d = blocks_q;
    hold_d   = hold_q;
    was_hb_d = was_hb_q;
    res_o    = '0;

    if (item_i.opcode == OpStart) begin
      // replace whatever transfer is running
      src_d    = item_i.start_source;
      dst_d    = item_i.start_dest;
      hold_d   = 1'b0;
      gen_d    = 1'b0;
      hb_d     = 1'b0;
      bytes_d  = '0;
      blocks_d = item_i.start_blocks;
      if (item_i.start_blocks != '0) begin
        if (item_i.start_hblank_mode) begin
          hb_d = 1'b1;
        end else begin
          gen_d   = 1'b1;
          bytes_d = (len > LEN_W'(BYTES_MAX)) ? BYTES_MAX : len[BYTES_W-1:0];
        end
      end
    end else begin
      if (do_copy) begin
        res_o.copy_valid  = 1'b1;
        res_o.copy_source = src_q;
        res_o.copy_dest   = dst_q;
        hold_d  = 1'b1;
        src_d   = src_q + ADDR_STEP;
        dst_d   = dst_q + ADDR_STEP;
        bytes_d = bytes_nxt;
        if (bytes_nxt == '0) begin
          hold_d = 1'b0;
          if (gen_q) begin
            gen_d          = 1'b0;
            res_o.finished = 1'b1;
          end else begin
            blocks_d = blocks_nxt;
            if (blocks_nxt == '0) begin
              hb_d           = 1'b0;
              res_o.finished = 1'b1;
            end
          end
        end
      end
      // arm one block on a rising edge of hblank
      if (hb_d && !was_hb_q && item_i.in_hblank) begin
        bytes_d = ARM_BYTES;
      end
      was_hb_d = item_i.in_hblank;
    end

    res_o.cpu_clock_enable = !hold_d;
    res_o.busy             = gen_d || hb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q    <= 1'b0;
      hb_q     <= 1'b0;
      src_q    <= '0;
      dst_q    <= '0;
      bytes_q  <= '0;
      blocks_q <= '0;
      hold_q   <= 1'b0;
      was_hb_q <= 1'b0;
    end else if (step_i) begin
      gen_q    <= gen_d;
      hb_q     <= hb_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      bytes_q  <= bytes_d;
      blocks_q <= blocks_d;
      hold_q   <= hold_d;
      was_hb_q <= was_hb_d;
    end
  end

  a_one_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(gen_q && hb_q))
    else $error("general and hblank transfers both running");

  a_hold_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> (gen_q || hb_q))
    else $error("cpu held with no transfer running");

  a_hold_hb_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q && hb_q) |-> (bytes_q != '0))
    else $error("hblank hold with no bytes pending");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.finished) |=> !(gen_q || hb_q || hold_q))
    else $error("transfer still active after completion");

endmodule

@@ rtl/core/vram_dma_sequencer.sv @@
// Output: a result is registered and shown in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; the output register drains while the next
//   transaction is taken, so in_stall_o rises only while a result waits under out_stall_i.
// Reset: rst_ni is asynchronous, active low; it stops all transfers, clears the
//   addresses and counters and empties the output register.
module vram_dma_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic                         cpu_idle_i,
  input  logic                         in_hblank_i,
  input  logic [vds_pkg::ADDR_W-1:0]   start_source_i,
  input  logic [vds_pkg::ADDR_W-1:0]   start_dest_i,
  input  logic                         start_hblank_mode_i,
  input  logic [vds_pkg::BLOCKS_W-1:0] start_blocks_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         copy_valid_o,
  output logic [vds_pkg::ADDR_W-1:0]   copy_source_o,
  output logic [vds_pkg::ADDR_W-1:0]   copy_dest_o,
  output logic                         cpu_clock_enable_o,
  output logic                         busy_res_o,
  output logic                         finished_o
);
  import vds_pkg::*;

  item_t item;
  res_t  res;
  res_t  res_q;
  logic  out_valid_q, out_valid_d;
  logic  accept;

  // Gather the input transaction fields.
  assign item.opcode            = op_e'(opcode_i);
  assign item.cpu_idle          = cpu_idle_i;
  assign item.in_hblank         = in_hblank_i;
  assign item.start_source      = start_source_i;
  assign item.start_dest        = start_dest_i;
  assign item.start_hblank_mode = start_hblank_mode_i;
  assign item.start_blocks      = start_blocks_i;

  // Hold the input only while a result waits and the sink stalls it.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // State registers and the per-tick sequencing logic.
  vds_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .item_i (item),
    .res_o  (res)
  );

  // Result register: load on accept, drop when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign copy_valid_o       = res_q.copy_valid;
  assign copy_source_o      = res_q.copy_source;
  assign copy_dest_o        = res_q.copy_dest;
  assign cpu_clock_enable_o = res_q.cpu_clock_enable;
  assign busy_res_o         = res_q.busy;
  assign finished_o         = res_q.finished;

endmodule
